@@ src/tspc_pkg.sv @@
// Shared types, action codes and constants for the session power controller.
package tspc_pkg;

  // Default session length in seconds
  localparam int unsigned SESSION_SECONDS_DEF = 300;

  // Battery bounds and limit register reset
  localparam logic [6:0]  BATT_FULL      = 7'd100;
  localparam logic [11:0] LIMIT_RESET    = 12'd30;
  localparam logic [11:0] WAIT_MAX       = 12'hFFF;

  // Fixed-point shift for the progress reciprocal
  localparam int unsigned PROG_SHIFT     = 20;

  // Action codes
  localparam logic [3:0] ACT_POWER_OFF   = 4'd0;
  localparam logic [3:0] ACT_POWER_ON    = 4'd1;
  localparam logic [3:0] ACT_CHARGER_ON  = 4'd2;
  localparam logic [3:0] ACT_CHARGER_OFF = 4'd3;
  localparam logic [3:0] ACT_CHARGE      = 4'd4;
  localparam logic [3:0] ACT_DRAIN       = 4'd5;
  localparam logic [3:0] ACT_LINK_UP     = 4'd6;
  localparam logic [3:0] ACT_LINK_DOWN   = 4'd7;
  localparam logic [3:0] ACT_PLAY_PAUSE  = 4'd8;
  localparam logic [3:0] ACT_STOP        = 4'd9;
  localparam logic [3:0] ACT_TICK        = 4'd10;

  // Input item
  typedef struct packed {
    logic [3:0] action;
    logic [6:0] amount;
  } evt_t;

  // Result item
  typedef struct packed {
    logic       power_on;
    logic       blue_led;
    logic       red_led;
    logic [6:0] battery_pct;
    logic       session_active;
    logic       session_paused;
    logic [8:0] seconds_left;
    logic [6:0] progress_pct;
    logic       auto_off;
  } res_t;

endpackage

@@ src/therapy_session_power_controller.sv @@
// Top level: event-driven power, battery, LED and session controller.
//
//  channel | signals                     | direction | payload
//  --------+-----------------------------+-----------+----------------
//  evt     | evt_valid, evt_stall, evt   | in        | evt_t
//  res     | res_valid, res_stall, res   | out       | res_t
//  cfg     | cfg_we, cfg_data            | in        | disconnect limit
//
// One item per cycle unless stalled: state update and result are computed in
// one pass and land in the state registers and the result register at the
// same edge; the path is set by one 9 x 19 bit constant multiply for the
// progress. A new item is taken while the result register is empty or being
// drained. Reset (rst, synchronous) restores power-up state and empties the
// result. A stalled result holds; evt_stall rises only while res is stalled.
module therapy_session_power_controller
  import tspc_pkg::*;
#(
  parameter int unsigned SESSION_SECONDS = SESSION_SECONDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        evt_valid,
  output logic        evt_stall,
  input  evt_t        evt,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data
);

  localparam logic [8:0]  SESS_LEN  = 9'(SESSION_SECONDS);
  // Rounded-up reciprocal of the length, scaled by 100; exact for 9-bit inputs
  localparam int unsigned PROG_MUL  =
    (100 * (1 << PROG_SHIFT) + SESSION_SECONDS - 1) / SESSION_SECONDS;
  localparam int unsigned MUL_W     = $clog2(PROG_MUL + 1);
  localparam int unsigned PROD_W    = MUL_W + 9;

  // State
  logic [11:0] limit;
  logic        powered, charger_attached, link_up, blue_lit, red_lit;
  logic [6:0]  battery_level;
  logic        in_session, paused_flag;
  logic [8:0]  countdown;
  logic [11:0] wait_count;

  logic        powered_next, charger_attached_next, link_up_next;
  logic        blue_lit_next, red_lit_next;
  logic [6:0]  battery_level_next;
  logic        in_session_next, paused_flag_next;
  logic [8:0]  countdown_next;
  logic [11:0] wait_count_next;
  logic        auto_off_next;

  logic        accept;
  logic [7:0]  charge_sum;
  logic [11:0] wait_inc;
  logic [8:0]  elapsed;
  logic [PROD_W-1:0] prog_prod;

  // Handshake
  assign evt_stall = res_valid & res_stall;
  assign accept    = evt_valid & ~evt_stall;

  assign charge_sum = {1'b0, battery_level} + {1'b0, evt.amount};
  assign wait_inc   = (wait_count < WAIT_MAX) ? wait_count + 12'd1 : wait_count;

  // Per-event state update
  always_comb begin
    powered_next          = powered;
    charger_attached_next = charger_attached;
    link_up_next          = link_up;
    blue_lit_next         = blue_lit;
    red_lit_next          = red_lit;
    battery_level_next    = battery_level;
    in_session_next       = in_session;
    paused_flag_next      = paused_flag;
    countdown_next        = countdown;
    wait_count_next       = wait_count;
    auto_off_next         = 1'b0;
    case (evt.action)
      ACT_POWER_OFF: begin
        powered_next  = 1'b0;
        blue_lit_next = 1'b0;
        red_lit_next  = 1'b0;
      end
      ACT_POWER_ON: begin
        powered_next  = 1'b1;
        blue_lit_next = link_up;
        red_lit_next  = ~link_up;
      end
      ACT_CHARGER_ON:  charger_attached_next = 1'b1;
      ACT_CHARGER_OFF: charger_attached_next = 1'b0;
      ACT_CHARGE: begin
        if (charger_attached && battery_level < BATT_FULL) begin
          battery_level_next = (charge_sum > {1'b0, BATT_FULL}) ? BATT_FULL
                                                                : charge_sum[6:0];
        end
      end
      ACT_DRAIN: begin
        if (powered && !charger_attached && battery_level != 7'd0) begin
          battery_level_next = (evt.amount >= battery_level) ? 7'd0
                                                             : battery_level - evt.amount;
        end
      end
      ACT_LINK_UP: begin
        link_up_next  = 1'b1;
        blue_lit_next = 1'b1;
        red_lit_next  = 1'b0;
        if (in_session && paused_flag) begin
          paused_flag_next = 1'b0;
          wait_count_next  = 12'd0;
        end
      end
      ACT_LINK_DOWN: begin
        link_up_next  = 1'b0;
        blue_lit_next = 1'b0;
        red_lit_next  = 1'b1;
        if (in_session && !paused_flag) begin
          paused_flag_next = 1'b1;
          wait_count_next  = 12'd0;
        end
      end
      ACT_PLAY_PAUSE: begin
        if (!in_session) begin
          if (link_up) begin
            in_session_next  = 1'b1;
            paused_flag_next = 1'b0;
            countdown_next   = SESS_LEN;
            wait_count_next  = 12'd0;
          end
        end else begin
          paused_flag_next = ~paused_flag;
          wait_count_next  = 12'd0;
        end
      end
      ACT_STOP: begin
        if (in_session) begin
          in_session_next  = 1'b0;
          paused_flag_next = 1'b0;
          countdown_next   = SESS_LEN;
          wait_count_next  = 12'd0;
        end
      end
      ACT_TICK: begin
        if (in_session) begin
          if (!paused_flag) begin
            if (countdown != 9'd0) countdown_next = countdown - 9'd1;
          end else if (wait_inc >= limit) begin
            // paused too long: end session and power down
            in_session_next  = 1'b0;
            paused_flag_next = 1'b0;
            countdown_next   = SESS_LEN;
            wait_count_next  = 12'd0;
            powered_next     = 1'b0;
            blue_lit_next    = 1'b0;
            red_lit_next     = 1'b0;
            auto_off_next    = 1'b1;
          end else begin
            wait_count_next  = wait_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // Progress: elapsed * 100 / length via scaled reciprocal
  assign elapsed   = SESS_LEN - countdown_next;
  assign prog_prod = PROD_W'(elapsed) * PROD_W'(PROG_MUL);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      powered          <= 1'b0;
      charger_attached <= 1'b0;
      link_up          <= 1'b1;
      blue_lit         <= 1'b0;
      red_lit          <= 1'b0;
      battery_level    <= BATT_FULL;
      in_session       <= 1'b0;
      paused_flag      <= 1'b0;
      countdown        <= SESS_LEN;
      wait_count       <= 12'd0;
    end else if (accept) begin
      powered          <= powered_next;
      charger_attached <= charger_attached_next;
      link_up          <= link_up_next;
      blue_lit         <= blue_lit_next;
      red_lit          <= red_lit_next;
      battery_level    <= battery_level_next;
      in_session       <= in_session_next;
      paused_flag      <= paused_flag_next;
      countdown        <= countdown_next;
      wait_count       <= wait_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.power_on       <= powered_next;
      res.blue_led       <= blue_lit_next;
      res.red_led        <= red_lit_next;
      res.battery_pct    <= battery_level_next;
      res.session_active <= in_session_next;
      res.session_paused <= paused_flag_next;
      res.seconds_left   <= countdown_next;
      res.progress_pct   <= prog_prod[PROG_SHIFT +: 7];
      res.auto_off       <= auto_off_next;
    end
  end

endmodule

@@ src/tspc_checker.sv @@
// Port-level checker for the session power controller, with its bind.
module tspc_checker
  import tspc_pkg::*;
#(
  parameter int unsigned SESSION_SECONDS = SESSION_SECONDS_DEF
) (
  input logic clk,
  input logic rst,
  input logic evt_valid,
  input logic evt_stall,
  input evt_t evt,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // Accepted item always yields a result next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_stall) |=> res_valid)
    else $error("accepted item produced no result");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

  // Auto power-off leaves everything down
  a_auto_off: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.auto_off) |->
      (!res.power_on && !res.blue_led && !res.red_led && !res.session_active))
    else $error("auto off with device or session still up");

  // Idle session shows full countdown and no progress
  a_idle_session: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.session_active) |->
      (!res.session_paused && res.seconds_left == 9'(SESSION_SECONDS)
       && res.progress_pct == 7'd0))
    else $error("idle session with stale countdown");

endmodule

bind therapy_session_power_controller tspc_checker #(
  .SESSION_SECONDS(SESSION_SECONDS)
) u_tspc_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt_valid),
  .evt_stall (evt_stall),
  .evt       (evt),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

@@ test/session_state_checker.sv @@
// Checker for the session power controller: predicts each result and compares it.
module session_state_checker
  import tspc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        evt_valid,
  input  logic        evt_stall,
  input  evt_t        evt,
  input  logic        res_valid,
  input  logic        res_stall,
  input  res_t        res,
  input  logic        cfg_we,
  input  logic [11:0] cfg_data,
  output int          outstanding,
  output int          errors
);

  // Predicted device state
  logic        pwr, chg, link, blue, red;
  logic [6:0]  batt;
  logic        active, paused;
  logic [8:0]  left;
  logic [11:0] waited;
  logic [11:0] limit;

  res_t status_q[$];
  res_t want;
  int   n_results;

  // One line per mismatch, and count it
  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at result %0d: %s", n_results, msg);
  endtask

  // Ending a session puts the countdown back to full length
  function automatic void close_session();
    if (active) begin
      active = 1'b0;
      paused = 1'b0;
      left   = 9'(SESSION_SECONDS_DEF);
      waited = '0;
    end
  endfunction

  // Apply one event to the predicted state and return the status it reports
  function automatic res_t next_status(input evt_t e);
    res_t        r;
    logic        off_now;
    int unsigned sum;
    int unsigned prog;
    off_now = 1'b0;
    case (e.action)
      ACT_POWER_OFF: begin
        pwr  = 1'b0;
        blue = 1'b0;
        red  = 1'b0;
      end
      ACT_POWER_ON: begin
        pwr  = 1'b1;
        blue = link;
        red  = !link;
      end
      ACT_CHARGER_ON:  chg = 1'b1;
      ACT_CHARGER_OFF: chg = 1'b0;
      ACT_CHARGE: begin
        if (chg && batt < BATT_FULL) begin
          sum  = 32'(batt) + 32'(e.amount);
          batt = (sum > BATT_FULL) ? BATT_FULL : sum[6:0];
        end
      end
      ACT_DRAIN: begin
        if (pwr && !chg && batt != 7'd0) begin
          batt = (e.amount >= batt) ? 7'd0 : batt - e.amount;
        end
      end
      ACT_LINK_UP: begin
        link = 1'b1;
        blue = 1'b1;
        red  = 1'b0;
        if (active && paused) begin
          paused = 1'b0;
          waited = '0;
        end
      end
      ACT_LINK_DOWN: begin
        link = 1'b0;
        blue = 1'b0;
        red  = 1'b1;
        if (active && !paused) begin
          paused = 1'b1;
          waited = '0;
        end
      end
      ACT_PLAY_PAUSE: begin
        if (!active) begin
          if (link) begin
            active = 1'b1;
            paused = 1'b0;
            left   = 9'(SESSION_SECONDS_DEF);
            waited = '0;
          end
        end else begin
          paused = !paused;
          waited = '0;
        end
      end
      ACT_STOP: close_session();
      ACT_TICK: begin
        if (active) begin
          if (!paused) begin
            if (left != 9'd0) left = left - 9'd1;
          end else begin
            if (waited != WAIT_MAX) waited = waited + 12'd1;
            if (waited >= limit) begin
              close_session();
              pwr     = 1'b0;
              blue    = 1'b0;
              red     = 1'b0;
              off_now = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    prog = ((SESSION_SECONDS_DEF - 32'(left)) * 100) / SESSION_SECONDS_DEF;
    r.power_on       = pwr;
    r.blue_led       = blue;
    r.red_led        = red;
    r.battery_pct    = batt;
    r.session_active = active;
    r.session_paused = paused;
    r.seconds_left   = left;
    r.progress_pct   = prog[6:0];
    r.auto_off       = off_now;
    return r;
  endfunction

  // Track config, compare results, queue predictions
  always @(posedge clk) begin
    if (rst) begin
      pwr    = 1'b0;
      chg    = 1'b0;
      link   = 1'b1;
      blue   = 1'b0;
      red    = 1'b0;
      batt   = BATT_FULL;
      active = 1'b0;
      paused = 1'b0;
      left   = 9'(SESSION_SECONDS_DEF);
      waited = '0;
      limit  = LIMIT_RESET;
      status_q.delete();
    end else begin
      if (cfg_we) limit = cfg_data;
      if (res_valid && !res_stall) begin
        n_results++;
        if (status_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = status_q.pop_front();
          if (res !== want) begin
            report_mismatch($sformatf("got %h expected %h", res, want));
          end
        end
      end
      if (evt_valid && !evt_stall) status_q.push_back(next_status(evt));
    end
    outstanding = status_q.size();
  end

endmodule

@@ test/therapy_session_power_controller_tb.sv @@
// Testbench top for the session power controller: stimulus, idling and verdict.
module therapy_session_power_controller_tb;
  import tspc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  // Codes outside the defined action set
  localparam logic [3:0] ACT_UNUSED_LO = 4'd11;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        evt_valid = 1'b0;
  evt_t        evt       = '0;
  logic        evt_stall;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        cfg_we    = 1'b0;
  logic [11:0] cfg_data  = '0;

  int errors;
  int outstanding;
  int cycles;
  int stall_hold;
  bit src_quiet;
  bit sink_quiet;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  therapy_session_power_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  session_state_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .evt_valid   (evt_valid),
    .evt_stall   (evt_stall),
    .evt         (evt),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .errors      (errors)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (sink_quiet) begin
      res_stall <= 1'b0;
    end else begin
      res_stall  <= ($urandom_range(0, 2) == 0);
      stall_hold <= gap_len();
    end
  end

  // Present one item, hold it until taken, then maybe idle
  task automatic send_item(input logic [3:0] act, input logic [6:0] amt);
    int g;
    evt       <= '{action: act, amount: amt};
    evt_valid <= 1'b1;
    do @(posedge clk); while (evt_stall);
    g = src_quiet ? 0 : gap_len();
    if (g != 0) begin
      evt_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected result is back
  task automatic settle();
    evt_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [11:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [6:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 7'd0;
    if (r < 20) return 7'd127;
    if (r < 30) return 7'd100;
    return 7'($urandom_range(0, 127));
  endfunction

  // Session-heavy mix with some raw noise
  task automatic random_item();
    int         r;
    logic [3:0] act;
    r = $urandom_range(0, 99);
    if (r < 50)      act = ACT_TICK;
    else if (r < 56) act = ACT_LINK_DOWN;
    else if (r < 63) act = ACT_LINK_UP;
    else if (r < 69) act = ACT_PLAY_PAUSE;
    else if (r < 73) act = ACT_CHARGE;
    else if (r < 78) act = ACT_DRAIN;
    else if (r < 81) act = ACT_CHARGER_ON;
    else if (r < 84) act = ACT_CHARGER_OFF;
    else if (r < 87) act = ACT_POWER_ON;
    else if (r < 89) act = ACT_POWER_OFF;
    else if (r < 91) act = ACT_STOP;
    else             act = 4'($urandom_range(0, 15));
    send_item(act, pick_amount());
  endtask

  // One random phase under a given disconnect limit
  task automatic run_phase(input logic [11:0] lim, input int n);
    settle();
    write_limit(lim);
    src_quiet  = ($urandom_range(0, 3) == 0);
    sink_quiet <= ($urandom_range(0, 3) == 0);
    send_item(ACT_POWER_ON, pick_amount());
    send_item(ACT_LINK_UP, pick_amount());
    send_item(ACT_PLAY_PAUSE, pick_amount());
    repeat (n) random_item();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unused codes, battery limits, link and session paths
    send_item(ACT_TICK, 7'd0);
    send_item(ACT_UNUSED_LO, 7'd127);
    send_item(ACT_UNUSED_HI, 7'd0);
    send_item(ACT_DRAIN, 7'd10);
    send_item(ACT_POWER_ON, 7'd0);
    send_item(ACT_DRAIN, 7'd37);
    send_item(ACT_DRAIN, 7'd127);
    send_item(ACT_DRAIN, 7'd5);
    send_item(ACT_CHARGER_ON, 7'd0);
    send_item(ACT_DRAIN, 7'd20);
    send_item(ACT_CHARGE, 7'd50);
    send_item(ACT_CHARGE, 7'd127);
    send_item(ACT_CHARGE, 7'd1);
    send_item(ACT_CHARGER_OFF, 7'd0);
    send_item(ACT_CHARGE, 7'd5);
    send_item(ACT_LINK_DOWN, 7'd0);
    send_item(ACT_PLAY_PAUSE, 7'd0);
    send_item(ACT_STOP, 7'd0);
    send_item(ACT_LINK_UP, 7'd0);
    send_item(ACT_PLAY_PAUSE, 7'd0);
    send_item(ACT_TICK, 7'd0);
    send_item(ACT_POWER_OFF, 7'd0);
    send_item(ACT_TICK, 7'd0);
    send_item(ACT_LINK_DOWN, 7'd0);
    send_item(ACT_TICK, 7'd0);
    send_item(ACT_LINK_UP, 7'd0);
    send_item(ACT_PLAY_PAUSE, 7'd0);
    send_item(ACT_PLAY_PAUSE, 7'd0);
    send_item(ACT_PLAY_PAUSE, 7'd0);
    repeat (4) send_item(ACT_TICK, 7'd0);
    // limit lowered below the paused count: next tick powers off
    settle();
    write_limit(12'd2);
    send_item(ACT_TICK, 7'd0);

    // Full countdown, then hold at zero
    settle();
    write_limit(LIMIT_RESET);
    send_item(ACT_POWER_ON, 7'd0);
    send_item(ACT_LINK_UP, 7'd0);
    send_item(ACT_STOP, 7'd0);
    send_item(ACT_PLAY_PAUSE, 7'd0);
    repeat (305) send_item(ACT_TICK, pick_amount());
    send_item(ACT_STOP, 7'd0);

    // Random phases across limit settings, extremes included
    run_phase(12'd1, 210);
    run_phase(12'd4095, 210);
    run_phase(12'd0, 210);
    run_phase(12'd2, 210);
    run_phase(LIMIT_RESET, 210);
    run_phase(12'($urandom_range(3, 40)), 210);
    run_phase(12'($urandom_range(1, 4095)), 210);

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
